[hdl/skl_pkg.sv]
package skl_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned ProdW   = 3 * ChanW;
    localparam int unsigned ScaleSh = 7;
    localparam int unsigned NumW    = ProdW + ScaleSh;
    localparam int unsigned QuotW   = 8;
    localparam int unsigned AddrW   = 3;

    localparam logic [AddrW-1:0] RegLumaMin     = 3'd0;
    localparam logic [AddrW-1:0] RegLumaMax     = 3'd1;
    localparam logic [AddrW-1:0] RegBlueMin     = 3'd2;
    localparam logic [AddrW-1:0] RegBlueMax     = 3'd3;
    localparam logic [AddrW-1:0] RegRedMin      = 3'd4;
    localparam logic [AddrW-1:0] RegRedMax      = 3'd5;
    localparam logic [AddrW-1:0] RegRampWidth   = 3'd6;

    localparam logic [ChanW-1:0] RstLumaMin     = 8'd60;
    localparam logic [ChanW-1:0] RstLumaMax     = 8'd255;
    localparam logic [ChanW-1:0] RstBlueMin     = 8'd77;
    localparam logic [ChanW-1:0] RstBlueMax     = 8'd127;
    localparam logic [ChanW-1:0] RstRedMin      = 8'd133;
    localparam logic [ChanW-1:0] RstRedMax      = 8'd173;
    localparam logic [ChanW-1:0] RstRampWidth   = 8'd8;

    typedef struct packed {
        logic [ChanW-1:0] luma_min;
        logic [ChanW-1:0] luma_max;
        logic [ChanW-1:0] blue_chroma_min;
        logic [ChanW-1:0] blue_chroma_max;
        logic [ChanW-1:0] red_chroma_min;
        logic [ChanW-1:0] red_chroma_max;
        logic [ChanW-1:0] ramp_width;
    } skl_cfg_t;

    // three trapezoid memberships plus the ramp width they were taken with
    typedef struct packed {
        logic [ChanW-1:0] m_y;
        logic [ChanW-1:0] m_b;
        logic [ChanW-1:0] m_r;
        logic [ChanW-1:0] w;
    } skl_memb_t;

    typedef struct packed {
        logic [ProdW-1:0] num;
        logic [ProdW-1:0] den;
    } skl_prod_t;

endpackage

[hdl/skl_member.sv]
module skl_member (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [skl_pkg::ChanW-1:0]  luma,
    input  logic [skl_pkg::ChanW-1:0]  blue_chroma,
    input  logic [skl_pkg::ChanW-1:0]  red_chroma,
    input  skl_pkg::skl_cfg_t          cfg,
    output logic                       out_valid,
    input  logic                       out_ready,
    output skl_pkg::skl_memb_t         out_data
);

    logic               valid_reg;
    skl_pkg::skl_memb_t data_reg;
    skl_pkg::skl_memb_t data_next;

    function automatic logic [skl_pkg::ChanW-1:0] trap(
        input logic [skl_pkg::ChanW-1:0] v,
        input logic [skl_pkg::ChanW-1:0] lo,
        input logic [skl_pkg::ChanW-1:0] hi,
        input logic [skl_pkg::ChanW-1:0] w
    );
        logic signed [skl_pkg::ChanW+1:0] sv;
        logic signed [skl_pkg::ChanW+1:0] slo;
        logic signed [skl_pkg::ChanW+1:0] shi;
        logic signed [skl_pkg::ChanW+1:0] sw;
        logic signed [skl_pkg::ChanW+1:0] up;
        logic signed [skl_pkg::ChanW+1:0] dn;
        sv  = $signed({2'b00, v});
        slo = $signed({2'b00, lo});
        shi = $signed({2'b00, hi});
        sw  = $signed({2'b00, w});
        up  = slo + sw;
        dn  = shi - sw;
        // rule order matters where the two ramps overlap
        if (sv < slo) begin
            trap = '0;
        end else if (sv < up) begin
            trap = v - lo;
        end else if (sv <= dn) begin
            trap = w;
        end else if (sv <= shi) begin
            trap = hi - v;
        end else begin
            trap = '0;
        end
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next.m_y = trap(luma, cfg.luma_min, cfg.luma_max, cfg.ramp_width);
        data_next.m_b = trap(blue_chroma, cfg.blue_chroma_min, cfg.blue_chroma_max,
                             cfg.ramp_width);
        data_next.m_r = trap(red_chroma, cfg.red_chroma_min, cfg.red_chroma_max,
                             cfg.ramp_width);
        data_next.w   = cfg.ramp_width;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[hdl/skl_mult.sv]
module skl_mult (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  skl_pkg::skl_memb_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output skl_pkg::skl_prod_t out_data
);

    localparam int unsigned CW = skl_pkg::ChanW;
    localparam int unsigned PW = skl_pkg::ProdW;

    logic [1:0]        valid_reg;
    logic              en_a;
    logic              en_b;

    logic [2*CW-1:0]   p1_reg;
    logic [2*CW-1:0]   w2_reg;
    logic [CW-1:0]     mr_reg;
    logic [CW-1:0]     w_reg;

    logic [PW-1:0]     w3_full;
    skl_pkg::skl_prod_t prod_reg;
    skl_pkg::skl_prod_t prod_next;

    assign en_b      = !valid_reg[1] || out_ready;
    assign en_a      = !valid_reg[0] || en_b;
    assign in_ready  = en_a;
    assign out_valid = valid_reg[1];
    assign out_data  = prod_reg;

    assign w3_full = {{CW{1'b0}}, w2_reg} * {{(2*CW){1'b0}}, w_reg};

    always_comb begin
        prod_next.num = {{CW{1'b0}}, p1_reg} * {{(2*CW){1'b0}}, mr_reg};
        // zero width means all memberships are zero; a unit divisor then yields zero
        prod_next.den = (w_reg == '0) ? PW'(1) : w3_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en_a) begin
                valid_reg[0] <= in_valid;
            end
            if (en_b) begin
                valid_reg[1] <= valid_reg[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            p1_reg <= {{CW{1'b0}}, in_data.m_y} * {{CW{1'b0}}, in_data.m_b};
            w2_reg <= {{CW{1'b0}}, in_data.w} * {{CW{1'b0}}, in_data.w};
            mr_reg <= in_data.m_r;
            w_reg  <= in_data.w;
        end
        if (en_b) begin
            prod_reg <= prod_next;
        end
    end

endmodule

[hdl/skl_div.sv]
module skl_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  skl_pkg::skl_prod_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [skl_pkg::QuotW-1:0]  quotient
);

    localparam int unsigned Steps = skl_pkg::QuotW;
    localparam int unsigned NW    = skl_pkg::NumW;
    localparam int unsigned PW    = skl_pkg::ProdW;

    logic [Steps-1:0] valid_reg;
    logic [Steps-1:0] en;
    logic [NW-1:0]    rem_reg  [Steps-1];
    logic [PW-1:0]    den_reg  [Steps-1];
    logic [Steps-1:0] quot_reg [Steps];

    // a stage may load when it is empty or its content moves on
    always_comb begin
        en[Steps-1] = !valid_reg[Steps-1] || out_ready;
        for (int k = Steps - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[Steps-1];
    assign quotient  = quot_reg[Steps-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < Steps; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    // restoring division, one quotient bit per stage, msb first
    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [NW-1:0]    rem_in;
        logic [PW-1:0]    den_in;
        logic [Steps-1:0] quot_in;
        logic [NW-1:0]    den_sh;
        logic             fits;
        logic [NW-1:0]    rem_next;
        logic [Steps-1:0] quot_next;

        if (k == 0) begin : g_first
            assign rem_in  = {in_data.num, {skl_pkg::ScaleSh{1'b0}}};
            assign den_in  = in_data.den;
            assign quot_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quot_in = quot_reg[k-1];
        end

        assign den_sh    = {{(NW-PW){1'b0}}, den_in} << (Steps - 1 - k);
        assign fits      = rem_in >= den_sh;
        assign rem_next  = fits ? (rem_in - den_sh) : rem_in;
        assign quot_next = quot_in | (Steps'(fits) << (Steps - 1 - k));

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                quot_reg[k] <= quot_next;
            end
        end

        if (k < Steps - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

endmodule

[hdl/skin_likelihood_mask.sv]
// Skin likelihood per YCbCr pixel, 0 (not skin) to 128 (fully skin). Each channel
// gets a trapezoid membership 0..W, the three are multiplied, scaled by 128 and
// divided by W cubed with truncation; a ramp width of zero gives 0. One pixel is
// accepted per clock unless back-pressure stalls it; each result passes through
// the membership register, the multiplier chain and the divider, which resolves
// one quotient bit per stage. Back-pressure on the result side only stalls the
// stages that are full, so empty slots keep taking pixels.
// Configuration registers are written through cfg_wr_en/cfg_addr/cfg_wdata and
// should only change while no pixel is in flight.
module skin_likelihood_mask (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [skl_pkg::ChanW-1:0]  s_luma,
    input  logic [skl_pkg::ChanW-1:0]  s_blue_chroma,
    input  logic [skl_pkg::ChanW-1:0]  s_red_chroma,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [skl_pkg::QuotW-1:0]  m_mask_level,

    input  logic                       cfg_wr_en,
    input  logic [skl_pkg::AddrW-1:0]  cfg_addr,
    input  logic [skl_pkg::ChanW-1:0]  cfg_wdata
);

    skl_pkg::skl_cfg_t  cfg_reg;

    logic               memb_valid;
    logic               memb_ready;
    skl_pkg::skl_memb_t memb_data;

    logic               prod_valid;
    logic               prod_ready;
    skl_pkg::skl_prod_t prod_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.luma_min        <= skl_pkg::RstLumaMin;
            cfg_reg.luma_max        <= skl_pkg::RstLumaMax;
            cfg_reg.blue_chroma_min <= skl_pkg::RstBlueMin;
            cfg_reg.blue_chroma_max <= skl_pkg::RstBlueMax;
            cfg_reg.red_chroma_min  <= skl_pkg::RstRedMin;
            cfg_reg.red_chroma_max  <= skl_pkg::RstRedMax;
            cfg_reg.ramp_width      <= skl_pkg::RstRampWidth;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                skl_pkg::RegLumaMin:   cfg_reg.luma_min        <= cfg_wdata;
                skl_pkg::RegLumaMax:   cfg_reg.luma_max        <= cfg_wdata;
                skl_pkg::RegBlueMin:   cfg_reg.blue_chroma_min <= cfg_wdata;
                skl_pkg::RegBlueMax:   cfg_reg.blue_chroma_max <= cfg_wdata;
                skl_pkg::RegRedMin:    cfg_reg.red_chroma_min  <= cfg_wdata;
                skl_pkg::RegRedMax:    cfg_reg.red_chroma_max  <= cfg_wdata;
                skl_pkg::RegRampWidth: cfg_reg.ramp_width      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    skl_member u_member (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .luma        (s_luma),
        .blue_chroma (s_blue_chroma),
        .red_chroma  (s_red_chroma),
        .cfg         (cfg_reg),
        .out_valid   (memb_valid),
        .out_ready   (memb_ready),
        .out_data    (memb_data)
    );

    skl_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (memb_valid),
        .in_ready  (memb_ready),
        .in_data   (memb_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    skl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .quotient  (m_mask_level)
    );

endmodule

[hdl/skl_checker.sv]
module skl_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [skl_pkg::QuotW-1:0]  m_mask_level
);

    // a held result stays put until its transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mask_level))
        else $error("result changed or dropped while stalled");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mask_level <= 8'd128)
        else $error("mask level above full scale");

    // pipeline comes out of reset empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    // input side can only back up when the result side is stalled
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind skin_likelihood_mask skl_checker u_skl_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_mask_level (m_mask_level)
);

[test/tb_skin_likelihood_mask.sv]
`timescale 1ns / 100ps

module tb_skin_likelihood_mask;

    localparam int unsigned ChanW = skl_pkg::ChanW;
    localparam int unsigned QuotW = skl_pkg::QuotW;
    localparam int unsigned AddrW = skl_pkg::AddrW;

    localparam int unsigned StallLimit = 5000;
    localparam int unsigned NumPhases  = 10;
    localparam int unsigned PhaseItems = 100;
    localparam int unsigned DrainWait  = 30;
    // beyond the last register, writes here must be ignored
    localparam logic [AddrW-1:0] RegUnused = 3'd7;

    typedef struct packed {
        logic [ChanW-1:0] luma;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] red;
    } pixel_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [ChanW-1:0] s_luma        = '0;
    logic [ChanW-1:0] s_blue_chroma = '0;
    logic [ChanW-1:0] s_red_chroma  = '0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [QuotW-1:0] m_mask_level;
    logic             cfg_wr_en;
    logic [AddrW-1:0] cfg_addr;
    logic [ChanW-1:0] cfg_wdata;

    pixel_t             pixel_q[$];
    logic [QuotW-1:0]   mask_q[$];
    skl_pkg::skl_cfg_t  cfg_model;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    int unsigned        mismatch_cnt  = 0;
    int unsigned        stall_cycles  = 0;

    skin_likelihood_mask i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_luma        (s_luma),
        .s_blue_chroma (s_blue_chroma),
        .s_red_chroma  (s_red_chroma),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mask_level  (m_mask_level),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int trapezoid(int v, int lo, int hi, int w);
        if (v < lo) return 0;
        if (v < lo + w) return v - lo;
        if (v <= hi - w) return w;
        if (v <= hi) return hi - v;
        return 0;
    endfunction

    function automatic logic [QuotW-1:0] predict_mask(pixel_t p);
        longint unsigned w;
        longint unsigned my;
        longint unsigned mb;
        longint unsigned mr;
        longint unsigned level;
        w = cfg_model.ramp_width;
        if (w == 0) return '0;
        my = trapezoid(p.luma, cfg_model.luma_min, cfg_model.luma_max, w);
        mb = trapezoid(p.blue, cfg_model.blue_chroma_min, cfg_model.blue_chroma_max, w);
        mr = trapezoid(p.red, cfg_model.red_chroma_min, cfg_model.red_chroma_max, w);
        level = (my * mb * mr * 128) / (w * w * w);
        return level[QuotW-1:0];
    endfunction

    // half the time anywhere, otherwise close to one of the trapezoid corners
    function automatic logic [ChanW-1:0] rand_chan(int lo, int hi, int w);
        int anchor;
        int v;
        if ($urandom_range(0, 1)) return ChanW'($urandom);
        anchor = $urandom_range(0, 1) ? lo : hi;
        v = anchor + int'($urandom_range(0, 2 * w + 4)) - (w + 2);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return ChanW'(v);
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p.luma = rand_chan(cfg_model.luma_min, cfg_model.luma_max, cfg_model.ramp_width);
        p.blue = rand_chan(cfg_model.blue_chroma_min, cfg_model.blue_chroma_max,
                           cfg_model.ramp_width);
        p.red  = rand_chan(cfg_model.red_chroma_min, cfg_model.red_chroma_max,
                           cfg_model.ramp_width);
        return p;
    endfunction

    task automatic write_reg(input logic [AddrW-1:0] idx, input logic [ChanW-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            skl_pkg::RegLumaMin:   cfg_model.luma_min        = val;
            skl_pkg::RegLumaMax:   cfg_model.luma_max        = val;
            skl_pkg::RegBlueMin:   cfg_model.blue_chroma_min = val;
            skl_pkg::RegBlueMax:   cfg_model.blue_chroma_max = val;
            skl_pkg::RegRedMin:    cfg_model.red_chroma_min  = val;
            skl_pkg::RegRedMax:    cfg_model.red_chroma_max  = val;
            skl_pkg::RegRampWidth: cfg_model.ramp_width      = val;
            default: ;
        endcase
    endtask

    task automatic load_cfg(input skl_pkg::skl_cfg_t c, input bit poke_unused);
        write_reg(skl_pkg::RegLumaMin,   c.luma_min);
        write_reg(skl_pkg::RegLumaMax,   c.luma_max);
        write_reg(skl_pkg::RegBlueMin,   c.blue_chroma_min);
        write_reg(skl_pkg::RegBlueMax,   c.blue_chroma_max);
        write_reg(skl_pkg::RegRedMin,    c.red_chroma_min);
        write_reg(skl_pkg::RegRedMax,    c.red_chroma_max);
        write_reg(skl_pkg::RegRampWidth, c.ramp_width);
        if (poke_unused) write_reg(RegUnused, ChanW'($urandom));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || mask_q.size() != 0);
    endtask

    function automatic skl_pkg::skl_cfg_t phase_cfg(int unsigned phase);
        skl_pkg::skl_cfg_t c;
        c = cfg_model;
        case (phase)
            1: c.ramp_width = 8'd0;
            2: c = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255};
            // ramps overlap, the rising side wins
            3: c = '{8'd100, 8'd110, 8'd50, 8'd60, 8'd200, 8'd205, 8'd8};
            // bounds inverted
            4: c = '{8'd200, 8'd50, 8'd255, 8'd0, 8'd150, 8'd140, 8'd16};
            5: c = '{8'd10, 8'd20, 8'd0, 8'd255, 8'd128, 8'd128, 8'd1};
            default: begin
                c.luma_min        = ChanW'($urandom);
                c.blue_chroma_min = ChanW'($urandom);
                c.red_chroma_min  = ChanW'($urandom);
                c.luma_max        = ChanW'($urandom);
                c.blue_chroma_max = ChanW'(c.blue_chroma_min + $urandom_range(0, 80));
                c.red_chroma_max  = ChanW'(c.red_chroma_min + $urandom_range(0, 80));
                c.ramp_width      = $urandom_range(0, 3) != 0 ? ChanW'($urandom_range(1, 40))
                                                               : ChanW'($urandom);
            end
        endcase
        return c;
    endfunction

    initial begin
        int     y_edges[7]  = '{59, 60, 67, 68, 247, 248, 255};
        int     cb_edges[5] = '{76, 77, 84, 127, 128};
        int     cr_edges[5] = '{132, 133, 141, 166, 174};
        pixel_t px;

        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = skl_pkg::RegLumaMin;
        cfg_wdata = '0;
        cfg_model = '{skl_pkg::RstLumaMin, skl_pkg::RstLumaMax, skl_pkg::RstBlueMin,
                      skl_pkg::RstBlueMax, skl_pkg::RstRedMin, skl_pkg::RstRedMax,
                      skl_pkg::RstRampWidth};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int unsigned phase = 0; phase < NumPhases; phase++) begin
            wait_drained();
            if (phase != 0) load_cfg(phase_cfg(phase), phase == 6);
            @(posedge aclk);
            if (phase < 4) begin
                send_idle_pct <= 27;
                recv_idle_pct <= 83;
            end else if (phase < 7) begin
                send_idle_pct <= 83;
                recv_idle_pct <= 27;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            if (phase == 0) begin
                // corners of the default trapezoids, the rest held fully inside
                pixel_q.push_back('{8'd150, 8'd100, 8'd150});
                pixel_q.push_back('{8'd0, 8'd0, 8'd0});
                pixel_q.push_back('{8'd255, 8'd255, 8'd255});
                pixel_q.push_back('{8'd64, 8'd81, 8'd137});
                foreach (y_edges[i]) pixel_q.push_back('{8'(y_edges[i]), 8'd100, 8'd150});
                foreach (cb_edges[i]) pixel_q.push_back('{8'd150, 8'(cb_edges[i]), 8'd150});
                foreach (cr_edges[i]) pixel_q.push_back('{8'd150, 8'd100, 8'(cr_edges[i])});
            end
            repeat (PhaseItems) begin
                px = rand_pixel();
                pixel_q.push_back(px);
            end
        end

        wait_drained();
        repeat (DrainWait) @(posedge aclk);
        if (mismatch_cnt == 0 && mask_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // pixel driver, the expectation is taken at the transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) mask_q.push_back(predict_mask('{s_luma, s_blue_chroma, s_red_chroma}));
            if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                pixel_t nxt;
                nxt = pixel_q.pop_front();
                s_valid       <= 1'b1;
                s_luma        <= nxt.luma;
                s_blue_chroma <= nxt.blue;
                s_red_chroma  <= nxt.red;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        logic [QuotW-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (mask_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected mask level %0d", $realtime, m_mask_level);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    want = mask_q.pop_front();
                    if (m_mask_level !== want) begin
                        if (mismatch_cnt < 10)
                            $display("%0t: mask level expected %0d, got %0d",
                                     $realtime, want, m_mask_level);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= StallLimit) begin
            $display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
